// ===== hw/rtl/pps_pkg.sv =====
package pps_pkg;

   // default sizes
   localparam int COORD_WIDTH_DEF  = 24;
   localparam int CORDIC_STEPS_DEF = 16;

   // fixed field widths
   localparam int YAW_W    = 16;
   localparam int LEN_W    = 23;
   localparam int SPEED_W  = 8;
   localparam int STEER_W  = 15;
   localparam int ANG_W    = 20;
   localparam int STEP_W   = 5;
   localparam int MUL_AW   = 31;
   localparam int PROD_W   = 2 * MUL_AW;

   // angle constants, Q.16 radians (STEER_MAX in Q.13)
   localparam logic signed [ANG_W-1:0] ANG_PI      = 20'sd205887;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 20'sd102944;
   localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 20'sd411775;
   localparam logic signed [ANG_W:0]   STEER_MAX   = 21'sd12868;

   // register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEELBASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED     = 2'd2;

   localparam logic [LEN_W-1:0]   LOOKAHEAD_RST = 23'd2560;
   localparam logic [LEN_W-1:0]   WHEELBASE_RST = 23'd256;
   localparam logic [SPEED_W-1:0] SPEED_RST     = 8'd15;

   // arctangent of 2^-i, Q.16 radians
   function automatic logic signed [ANG_W-1:0] atan_val(input logic [STEP_W-1:0] idx);
      logic signed [ANG_W-1:0] v;
      unique case (idx)
         5'd0:    v = 20'sd51472;
         5'd1:    v = 20'sd30385;
         5'd2:    v = 20'sd16055;
         5'd3:    v = 20'sd8150;
         5'd4:    v = 20'sd4091;
         5'd5:    v = 20'sd2047;
         5'd6:    v = 20'sd1024;
         5'd7:    v = 20'sd512;
         5'd8:    v = 20'sd256;
         5'd9:    v = 20'sd128;
         5'd10:   v = 20'sd64;
         5'd11:   v = 20'sd32;
         5'd12:   v = 20'sd16;
         5'd13:   v = 20'sd8;
         5'd14:   v = 20'sd4;
         5'd15:   v = 20'sd2;
         5'd16:   v = 20'sd1;
         default: v = 20'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/pps_if.sv =====
interface pps_req_if import pps_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vehicle_x;
   logic signed [COORD_WIDTH-1:0] vehicle_y;
   logic signed [YAW_W-1:0]       vehicle_yaw;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          point_valid;
   logic                          last_point;

   modport source (output valid, vehicle_x, vehicle_y, vehicle_yaw, point_x, point_y,
                   point_valid, last_point, input ready);
   modport sink (input valid, vehicle_x, vehicle_y, vehicle_yaw, point_x, point_y,
                 point_valid, last_point, output ready);
endinterface

interface pps_rsp_if import pps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [STEER_W-1:0] steering;
   logic [SPEED_W-1:0]        velocity_kph;
   logic                      target_found;

   modport source (output valid, steering, velocity_kph, target_found, input ready);
   modport sink (input valid, steering, velocity_kph, target_found, output ready);
endinterface

interface pps_csr_if import pps_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [LEN_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pps_cordic_step.sv =====
module pps_cordic_step import pps_pkg::*; #(
   parameter int CW = 36
) (
   input  logic                    vec_mode,
   input  logic signed [CW-1:0]    x_cur,
   input  logic signed [CW-1:0]    y_cur,
   input  logic signed [ANG_W-1:0] z_cur,
   input  logic [STEP_W-1:0]       step,
   output logic signed [CW-1:0]    x_nxt,
   output logic signed [CW-1:0]    y_nxt,
   output logic signed [ANG_W-1:0] z_nxt
);

   logic signed [CW-1:0]    xs;
   logic signed [CW-1:0]    ys;
   logic signed [ANG_W-1:0] a;
   logic                    ccw;

   // one micro-rotation, direction from angle or from sign of y
   always_comb begin
      xs  = x_cur >>> step;
      ys  = y_cur >>> step;
      a   = atan_val(step);
      ccw = vec_mode ? y_cur[CW-1] : !z_cur[ANG_W-1];
      if (ccw) begin
         x_nxt = x_cur - ys;
         y_nxt = y_cur + xs;
         z_nxt = z_cur - a;
      end else begin
         x_nxt = x_cur + ys;
         y_nxt = y_cur - xs;
         z_nxt = z_cur + a;
      end
   end

endmodule

// ===== hw/rtl/pps_mul.sv =====
module pps_mul import pps_pkg::*; (
   input  logic              clock,
   input  logic [MUL_AW-1:0] mul_a,
   input  logic [MUL_AW-1:0] mul_b,
   output logic [PROD_W-1:0] prod_ff
);

   // registered unsigned product
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

// ===== hw/rtl/pure_pursuit_steering.sv =====
// channel | dir | transfer when   | payload
// req_if  | in  | valid && ready  | pose, path point, point_valid, last_point
// rsp_if  | out | valid && ready  | steering, velocity_kph, target_found
// csr_if  | in  | valid && ready  | index, data (lookahead, wheelbase, speed)
// a skipped item is not processed; a point uses the shared cordic step and multiplier;
// a frame close with a target makes normalizing shifts of the atan2 operands, then runs
// the bit-per-cycle square root (31 steps) and the vectoring pass; an empty close goes
// straight to the output.
// reset is synchronous and clears the sequencer, target and registers to defaults.
// ready drops while an item is in work; a held result stalls only the frame close.
module pure_pursuit_steering import pps_pkg::*; #(
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pps_req_if.sink   req_if,
   pps_rsp_if.source rsp_if,
   pps_csr_if.sink   csr_if
);

   localparam int W  = COORD_WIDTH;
   localparam int TW = W + 3;
   localparam int CW = (W + 4 > 34) ? W + 4 : 34;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
   localparam logic [PROD_W-1:0] SQRT_BIT0 = PROD_W'(1) << 60;

   typedef enum logic [4:0] {
      S_IDLE, S_ROT_INIT, S_ROT, S_DIST0, S_DIST1, S_DIST2, S_DIST3,
      S_FIN, S_NORM1, S_SQA, S_SQB, S_SQC, S_SQRT, S_NUMA, S_NUMB, S_NUMC,
      S_NORM2, S_VEC, S_ROUND, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]   look_ff, look_in, wb_ff, wb_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;

   logic                last_ff, last_in;
   logic signed [W-1:0] vx_ff, vx_in, vy_ff, vy_in, px_ff, px_in, py_ff, py_in;
   logic signed [YAW_W-1:0] yaw_ff, yaw_in;

   logic signed [CW-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic [STEP_W-1:0]       i_ff, i_in;
   logic [CW-1:0]           mx_ff, mx_in, my_ff, my_in;
   logic [PROD_W-1:0]       acc_ff, acc_in;

   logic                 found_ff, found_in;
   logic signed [TW-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [CW-1:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic                 neg_ff, neg_in;
   logic [PROD_W-1:0]    v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [PROD_W-1:0]    num_ff, num_in, den_ff, den_in;
   logic signed [STEER_W-1:0] sres_ff, sres_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [STEER_W-1:0] rsp_steer_ff, rsp_steer_in;
   logic [SPEED_W-1:0]        rsp_vel_ff, rsp_vel_in;
   logic                      rsp_tf_ff, rsp_tf_in;

   logic [MUL_AW-1:0]       mul_a, mul_b;
   logic [PROD_W-1:0]       prod_ff;
   logic signed [CW-1:0]    cx_nxt, cy_nxt;
   logic signed [ANG_W-1:0] cz_nxt;
   logic                    vec_mode;

   // shared arithmetic
   pps_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   pps_cordic_step #(.CW(CW)) u_step (
      .vec_mode (vec_mode),
      .x_cur    (x_ff),
      .y_cur    (y_ff),
      .z_cur    (z_ff),
      .step     (i_ff),
      .x_nxt    (cx_nxt),
      .y_nxt    (cy_nxt),
      .z_nxt    (cz_nxt)
   );

   assign vec_mode      = (state_ff == S_VEC);
   assign req_if.ready  = (state_ff == S_IDLE);
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.steering     = rsp_steer_ff;
   assign rsp_if.velocity_kph = rsp_vel_ff;
   assign rsp_if.target_found = rsp_tf_ff;

   // sequencer
   always_comb begin
      logic signed [CW-1:0]    dx, dy, tq;
      logic signed [ANG_W-1:0] zq;
      logic [PROD_W-1:0]       sum;
      logic signed [ANG_W:0]   zr, s;
      logic                    far;

      state_in = state_ff;
      look_in = look_ff; wb_in = wb_ff; speed_in = speed_ff;
      last_in = last_ff;
      vx_in = vx_ff; vy_in = vy_ff; px_in = px_ff; py_in = py_ff; yaw_in = yaw_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      mx_in = mx_ff; my_in = my_ff; acc_in = acc_ff;
      found_in = found_ff; tx_in = tx_ff; ty_in = ty_ff;
      ax_in = ax_ff; ay_in = ay_ff; neg_in = neg_ff;
      v_in = v_ff; res_in = res_ff; bit_in = bit_ff;
      num_in = num_ff; den_in = den_ff; sres_in = sres_ff;
      rsp_valid_in = rsp_valid_ff; rsp_steer_in = rsp_steer_ff;
      rsp_vel_in = rsp_vel_ff; rsp_tf_in = rsp_tf_ff;
      mul_a = '0; mul_b = '0;
      dx = '0; dy = '0; tq = '0; zq = '0; sum = '0; zr = '0; s = '0; far = 1'b0;

      // register writes
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_LOOKAHEAD: look_in  = csr_if.data;
            CSR_WHEELBASE: wb_in    = csr_if.data;
            CSR_SPEED:     speed_in = csr_if.data[SPEED_W-1:0];
            default: ;
         endcase
      end

      if (rsp_if.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               last_in = req_if.last_point;
               vx_in = req_if.vehicle_x; vy_in = req_if.vehicle_y;
               px_in = req_if.point_x; py_in = req_if.point_y;
               yaw_in = req_if.vehicle_yaw;
               if (req_if.point_valid && !found_ff) state_in = S_ROT_INIT;
               else if (req_if.last_point)        state_in = S_FIN;
            end
         end
         // offset, magnitudes and angle reduction
         S_ROT_INIT: begin
            dx = CW'(px_ff) - CW'(vx_ff);
            dy = CW'(py_ff) - CW'(vy_ff);
            mx_in = dx[CW-1] ? CW'(-dx) : CW'(dx);
            my_in = dy[CW-1] ? CW'(-dy) : CW'(dy);
            zq = -(ANG_W'(yaw_ff) <<< 3);
            if (zq > ANG_PI) zq = zq - ANG_TWO_PI;
            if (zq < -ANG_PI) zq = zq + ANG_TWO_PI;
            if (zq > ANG_HALF_PI) begin
               x_in = -dy; y_in = dx; z_in = zq - ANG_HALF_PI;
            end else if (zq < -ANG_HALF_PI) begin
               x_in = dy; y_in = -dx; z_in = zq + ANG_HALF_PI;
            end else begin
               x_in = dx; y_in = dy; z_in = zq;
            end
            i_in = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            x_in = cx_nxt; y_in = cy_nxt; z_in = cz_nxt;
            i_in = i_ff + 1'b1;
            if (i_ff == LAST_STEP) state_in = S_DIST0;
         end
         // squared distance against squared lookahead
         S_DIST0: begin
            mul_a = mx_ff[MUL_AW-1:0]; mul_b = mx_ff[MUL_AW-1:0];
            state_in = S_DIST1;
         end
         S_DIST1: begin
            mul_a = my_ff[MUL_AW-1:0]; mul_b = my_ff[MUL_AW-1:0];
            acc_in = prod_ff;
            state_in = S_DIST2;
         end
         S_DIST2: begin
            mul_a = MUL_AW'(look_ff); mul_b = MUL_AW'(look_ff);
            acc_in = acc_ff + prod_ff;
            state_in = S_DIST3;
         end
         S_DIST3: begin
            far = (mx_ff >= CW'(look_ff)) || (my_ff >= CW'(look_ff)) || (acc_ff >= prod_ff);
            if (x_ff > 0 && far) begin
               found_in = 1'b1;
               tx_in = x_ff[TW-1:0]; ty_in = y_ff[TW-1:0];
            end
            state_in = last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            tq = CW'(tx_ff); ax_in = tq[CW-1] ? CW'(-tq) : CW'(tq);
            tq = CW'(ty_ff); ay_in = tq[CW-1] ? CW'(-tq) : CW'(tq);
            neg_in = ty_ff[TW-1];
            state_in = found_ff ? S_NORM1 : S_OUT;
         end
         S_NORM1: begin
            if ((|ax_ff[CW-1:30]) || (|ay_ff[CW-1:30])) begin
               ax_in = ax_ff >> 1; ay_in = ay_ff >> 1;
            end else if (ay_ff == '0) begin
               sres_in = '0; state_in = S_OUT;
            end else begin
               state_in = S_SQA;
            end
         end
         S_SQA: begin
            mul_a = ax_ff[MUL_AW-1:0]; mul_b = ax_ff[MUL_AW-1:0];
            state_in = S_SQB;
         end
         S_SQB: begin
            mul_a = ay_ff[MUL_AW-1:0]; mul_b = ay_ff[MUL_AW-1:0];
            acc_in = prod_ff;
            state_in = S_SQC;
         end
         S_SQC: begin
            v_in = acc_ff + prod_ff; res_in = '0; bit_in = SQRT_BIT0;
            state_in = S_SQRT;
         end
         // one result bit per cycle
         S_SQRT: begin
            sum = res_ff + bit_ff;
            if (v_ff >= sum) begin
               v_in = v_ff - sum; res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) state_in = S_NUMA;
         end
         S_NUMA: begin
            mul_a = MUL_AW'(wb_ff); mul_b = ay_ff[MUL_AW-1:0];
            state_in = S_NUMB;
         end
         S_NUMB: begin
            num_in = prod_ff << 1;
            mul_a = MUL_AW'(look_ff); mul_b = res_ff[MUL_AW-1:0];
            state_in = S_NUMC;
         end
         S_NUMC: begin
            den_in = prod_ff;
            state_in = S_NORM2;
         end
         S_NORM2: begin
            if ((|den_ff[PROD_W-1:30]) || (|num_ff[PROD_W-1:30])) begin
               den_in = den_ff >> 1; num_in = num_ff >> 1;
            end else if (num_ff == '0) begin
               sres_in = '0; state_in = S_OUT;
            end else begin
               x_in = CW'(den_ff[29:0]); y_in = CW'(num_ff[29:0]);
               z_in = '0; i_in = '0;
               state_in = S_VEC;
            end
         end
         S_VEC: begin
            x_in = cx_nxt; y_in = cy_nxt; z_in = cz_nxt;
            i_in = i_ff + 1'b1;
            if (i_ff == LAST_STEP) state_in = S_ROUND;
         end
         // round half up to Q2.13 and saturate
         S_ROUND: begin
            zr = (ANG_W + 1)'(z_ff) + 21'sd4;
            s = zr >>> 3;
            if (z_ff[ANG_W-1]) s = '0;
            if (s > STEER_MAX) s = STEER_MAX;
            sres_in = neg_ff ? -s[STEER_W-1:0] : s[STEER_W-1:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_steer_in = found_ff ? sres_ff : '0;
               rsp_vel_in   = found_ff ? speed_ff : '0;
               rsp_tf_in    = found_ff;
               found_in = 1'b0; tx_in = '0; ty_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         look_ff <= LOOKAHEAD_RST; wb_ff <= WHEELBASE_RST; speed_ff <= SPEED_RST;
         found_ff <= 1'b0; tx_ff <= '0; ty_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         look_ff <= look_in; wb_ff <= wb_in; speed_ff <= speed_in;
         found_ff <= found_in; tx_ff <= tx_in; ty_ff <= ty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      vx_ff <= vx_in; vy_ff <= vy_in; px_ff <= px_in; py_ff <= py_in; yaw_ff <= yaw_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
      mx_ff <= mx_in; my_ff <= my_in; acc_ff <= acc_in;
      ax_ff <= ax_in; ay_ff <= ay_in; neg_ff <= neg_in;
      v_ff <= v_in; res_ff <= res_in; bit_ff <= bit_in;
      num_ff <= num_in; den_ff <= den_in; sres_ff <= sres_in;
      rsp_steer_ff <= rsp_steer_in; rsp_vel_ff <= rsp_vel_in; rsp_tf_ff <= rsp_tf_in;
   end

`ifndef SYNTHESIS
   a_clear_after_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && (!rsp_valid_ff || rsp_if.ready)) |=> !found_ff)
      else $error("target not cleared after frame close");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT || state_ff == S_VEC) |-> (i_ff <= LAST_STEP))
      else $error("cordic step beyond last");
   a_vec_x_nonneg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VEC) |-> !x_ff[CW-1])
      else $error("vectoring x went negative");
   a_nofind_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tf_ff) |-> (rsp_steer_ff == '0 && rsp_vel_ff == '0))
      else $error("nonzero result without target");
`endif

endmodule
